// ----- sv/firmware_update_header_checker_top_defines.svh -----
// -----------------------------------------------------------------------------
// Assertion macros for the firmware update header checker.
// Shared by the checker file; each macro expands to one labeled assertion.
// -----------------------------------------------------------------------------
`ifndef FIRMWARE_UPDATE_HEADER_CHECKER_TOP_DEFINES_SVH
`define FIRMWARE_UPDATE_HEADER_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define FUHC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define FUHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/fuhc_pkg.sv -----
// -----------------------------------------------------------------------------
// fuhc_pkg
// Types and constants shared by the firmware update header checker.
// -----------------------------------------------------------------------------
package fuhc_pkg;

  // Header layout.
  localparam int HEADER_BYTES = 128;
  localparam int SIG_CAPACITY = 72;

  localparam logic [7:0] POS_FORMAT   = 8'd4;
  localparam logic [7:0] POS_ROLE     = 8'd5;
  localparam logic [7:0] POS_RESERVED = 8'd6;
  localparam logic [7:0] POS_VERSION  = 8'd8;
  localparam logic [7:0] POS_SIZE     = 8'd12;
  localparam logic [7:0] POS_SIGLEN   = 8'd16;
  localparam logic [7:0] POS_SIG      = 8'd17;

  localparam logic [7:0] FORMAT_ID = 8'd1;

  localparam logic [7:0] MAGIC [4] = '{8'h43, 8'h4A, 8'h46, 8'h57};

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] word_t;
  typedef logic [7:0]  hdr_pos_t;

  typedef enum logic [3:0] {
    ST_RECEIVING     = 4'd0,
    ST_INSTALLED     = 4'd1,
    ST_BAD_HEADER    = 4'd2,
    ST_WRONG_ROLE    = 4'd3,
    ST_DOWNGRADE     = 4'd4,
    ST_TOO_LARGE     = 4'd5,
    ST_TRUNCATED     = 4'd6,
    ST_BAD_SIGNATURE = 4'd7,
    ST_WRITE_ERROR   = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    MODE_DATA   = 2'd0,
    MODE_FINISH = 2'd1,
    MODE_CANCEL = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_EXPECTED_ROLE   = 2'd0,
    CFG_RUNNING_VERSION = 2'd1,
    CFG_MAX_IMAGE_BYTES = 2'd2,
    CFG_UNUSED          = 2'd3
  } cfg_idx_t;

  localparam word_t MAX_IMAGE_RESET = 32'd1048576;

  // Verdict on one header byte.
  typedef struct packed {
    logic malformed;
    logic role_bad;
    logic version_load;
    logic size_load;
    logic siglen_load;
  } hdr_chk_t;

  // One result transaction.
  typedef struct packed {
    status_t status;
    logic    image_byte_valid;
    byte_t   image_byte;
    logic    begin_image;
    logic    abort_image;
    logic    commit_image;
    word_t   image_size;
    word_t   image_version;
  } out_item_t;

endpackage

// ----- sv/fuhc_channels.sv -----
// -----------------------------------------------------------------------------
// fuhc channels
// Valid/ready interfaces for the input stream and the result stream.
// -----------------------------------------------------------------------------
interface fuhc_in_if
  import fuhc_pkg::*;
  ();
  logic  valid;
  logic  ready;
  logic [1:0] mode;
  byte_t data_byte;
  logic  write_failed;
  logic  signature_valid;

  modport source (output valid, mode, data_byte, write_failed, signature_valid,
                  input ready);
  modport sink   (input valid, mode, data_byte, write_failed, signature_valid,
                  output ready);
endinterface

interface fuhc_out_if
  import fuhc_pkg::*;
  ();
  logic    valid;
  logic    ready;
  status_t status;
  logic    image_byte_valid;
  byte_t   image_byte;
  logic    begin_image;
  logic    abort_image;
  logic    commit_image;
  word_t   image_size;
  word_t   image_version;

  modport source (output valid, status, image_byte_valid, image_byte, begin_image,
                  abort_image, commit_image, image_size, image_version,
                  input ready);
  modport sink   (input valid, status, image_byte_valid, image_byte, begin_image,
                  abort_image, commit_image, image_size, image_version,
                  output ready);
endinterface

// ----- sv/fuhc_hdr_check.sv -----
// -----------------------------------------------------------------------------
// fuhc_hdr_check
// Judges one header byte against the field that sits at its position.
// -----------------------------------------------------------------------------
module fuhc_hdr_check
  import fuhc_pkg::*;
(
  input  hdr_pos_t pos,
  input  byte_t    data_byte,
  input  byte_t    sig_len,
  input  byte_t    expected_role,
  output hdr_chk_t chk
);

  hdr_pos_t sig_off;

  assign sig_off = pos - POS_SIG;

  always_comb begin
    chk = '0;
    priority if (pos < POS_FORMAT) begin
      chk.malformed = (data_byte != MAGIC[pos[1:0]]);
    end else if (pos == POS_FORMAT) begin
      chk.malformed = (data_byte != FORMAT_ID);
    end else if (pos == POS_ROLE) begin
      chk.role_bad = (data_byte != expected_role);
    end else if (pos < POS_VERSION) begin
      chk.malformed = (data_byte != '0);
    end else if (pos < POS_SIZE) begin
      chk.version_load = 1'b1;
    end else if (pos < POS_SIGLEN) begin
      chk.size_load = 1'b1;
    end else if (pos == POS_SIGLEN) begin
      chk.siglen_load = 1'b1;
      chk.malformed   = (data_byte == '0) || (data_byte > byte_t'(SIG_CAPACITY));
    end else begin
      // Past the signature, every byte is padding and must be zero.
      chk.malformed = (sig_off >= sig_len) && (data_byte != '0);
    end
  end

endmodule

// ----- sv/firmware_update_header_checker_top.sv -----
// -----------------------------------------------------------------------------
// firmware_update_header_checker_top
// Header checker for a byte-wise firmware update stream.
// -----------------------------------------------------------------------------
// Usage: in_ch carries one stream transaction per handshake (a data byte,
// finish, cancel or no-op, with the sink and verifier verdicts). Each input
// transaction yields exactly one result transaction on out_ch, carrying the
// status after it, the image byte if the byte belongs to the image, and the
// begin/abort/commit pulses.
// The result is registered. Throughput is one transaction per cycle while
// in_ch.ready is high: the header checks and counters settle in one
// pass of logic ahead of the result register.
// Behind the result register sits a one-entry skid buffer, so a transaction
// is still taken while a result waits; in_ch.ready drops only when both hold
// results, and rises again once out_ch takes one.
// Reset (rst_n low at a clock edge) returns the block to receiving with an
// empty header, drops any pending results and restores the configuration
// defaults. Configuration is written through cfg_we/cfg_index/cfg_wdata
// while the block is idle; writes to an unused index are ignored.
// -----------------------------------------------------------------------------
module firmware_update_header_checker_top
  import fuhc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  cfg_idx_t        cfg_index,
  input  word_t           cfg_wdata,
  fuhc_in_if.sink         in_ch,
  fuhc_out_if.source      out_ch
);

  // Configuration.
  byte_t exp_role_r;
  word_t run_ver_r;
  word_t max_bytes_r;

  // Stream state.
  status_t  status_r,    status_nxt;
  hdr_pos_t hdr_cnt_r,   hdr_cnt_nxt;
  logic     malformed_r, malformed_nxt;
  logic     role_bad_r,  role_bad_nxt;
  byte_t    siglen_r,    siglen_nxt;
  word_t    version_r,   version_nxt;
  word_t    size_r,      size_nxt;
  word_t    written_r,   written_nxt;

  // Result register and skid entry.
  out_item_t out_r,   skid_r;
  logic      out_v_r, skid_v_r;
  out_item_t res;

  hdr_chk_t chk;
  logic     hdr_done;
  logic     in_fire;
  logic     out_fire;
  mode_t    mode;

  assign mode     = mode_t'(in_ch.mode);
  assign hdr_done = (hdr_cnt_r >= hdr_pos_t'(HEADER_BYTES));
  assign in_ch.ready = !skid_v_r;
  assign in_fire  = in_ch.valid && !skid_v_r;
  assign out_fire = out_v_r && out_ch.ready;

  fuhc_hdr_check u_hdr_check (
    .pos           (hdr_cnt_r),
    .data_byte     (in_ch.data_byte),
    .sig_len       (siglen_r),
    .expected_role (exp_role_r),
    .chk           (chk)
  );

  always_comb begin
    status_nxt    = status_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    malformed_nxt = malformed_r;
    role_bad_nxt  = role_bad_r;
    siglen_nxt    = siglen_r;
    version_nxt   = version_r;
    size_nxt      = size_r;
    written_nxt   = written_r;
    res           = '0;

    if (status_r == ST_RECEIVING) begin
      unique case (mode)
        MODE_DATA: begin
          if (!hdr_done) begin
            hdr_cnt_nxt   = hdr_cnt_r + 8'd1;
            malformed_nxt = malformed_r | chk.malformed;
            role_bad_nxt  = role_bad_r | chk.role_bad;
            if (chk.version_load) version_nxt = {version_r[23:0], in_ch.data_byte};
            if (chk.size_load)    size_nxt    = {size_r[23:0], in_ch.data_byte};
            if (chk.siglen_load)  siglen_nxt  = in_ch.data_byte;
            // The last header byte settles the verdict on the whole header.
            if (hdr_cnt_r == hdr_pos_t'(HEADER_BYTES - 1)) begin
              priority if (malformed_nxt) begin
                status_nxt = ST_BAD_HEADER;
              end else if (role_bad_nxt) begin
                status_nxt = ST_WRONG_ROLE;
              end else if ((run_ver_r != '0) && (version_nxt < run_ver_r)) begin
                status_nxt = ST_DOWNGRADE;
              end else if ((size_nxt == '0) || (size_nxt > max_bytes_r)) begin
                status_nxt = ST_TOO_LARGE;
              end else if (in_ch.write_failed) begin
                status_nxt = ST_WRITE_ERROR;
              end else begin
                res.begin_image = 1'b1;
              end
            end
          end else if (written_r >= size_r) begin
            status_nxt      = ST_TOO_LARGE;
            res.abort_image = 1'b1;
          end else if (in_ch.write_failed) begin
            status_nxt      = ST_WRITE_ERROR;
            res.abort_image = 1'b1;
          end else begin
            res.image_byte_valid = 1'b1;
            res.image_byte       = in_ch.data_byte;
            written_nxt          = written_r + 32'd1;
          end
        end
        MODE_FINISH: begin
          priority if (!hdr_done || (written_r != size_r)) begin
            status_nxt      = ST_TRUNCATED;
            res.abort_image = hdr_done;
          end else if (in_ch.write_failed) begin
            status_nxt      = ST_WRITE_ERROR;
            res.abort_image = 1'b1;
          end else if (!in_ch.signature_valid) begin
            status_nxt      = ST_BAD_SIGNATURE;
            res.abort_image = 1'b1;
          end else begin
            status_nxt       = ST_INSTALLED;
            res.commit_image = 1'b1;
          end
        end
        MODE_CANCEL: begin
          status_nxt      = ST_TRUNCATED;
          res.abort_image = hdr_done;
        end
        MODE_NOP: begin
        end
        default: begin
        end
      endcase
    end

    res.status        = status_nxt;
    res.image_size    = size_nxt;
    res.image_version = version_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_role_r  <= '0;
      run_ver_r   <= '0;
      max_bytes_r <= MAX_IMAGE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPECTED_ROLE:   exp_role_r  <= cfg_wdata[7:0];
        CFG_RUNNING_VERSION: run_ver_r   <= cfg_wdata;
        CFG_MAX_IMAGE_BYTES: max_bytes_r <= cfg_wdata;
        CFG_UNUSED: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Stream state advances on every accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= ST_RECEIVING;
      hdr_cnt_r   <= '0;
      malformed_r <= 1'b0;
      role_bad_r  <= 1'b0;
      siglen_r    <= '0;
      version_r   <= '0;
      size_r      <= '0;
      written_r   <= '0;
    end else if (in_fire) begin
      status_r    <= status_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      malformed_r <= malformed_nxt;
      role_bad_r  <= role_bad_nxt;
      siglen_r    <= siglen_nxt;
      version_r   <= version_nxt;
      size_r      <= size_nxt;
      written_r   <= written_nxt;
    end
  end

  // Result register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_fire) begin
        skid_v_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_v_r || out_fire) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_fire) out_r <= skid_r;
    end else if (in_fire) begin
      if (!out_v_r || out_fire) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.status           = out_r.status;
  assign out_ch.image_byte_valid = out_r.image_byte_valid;
  assign out_ch.image_byte       = out_r.image_byte;
  assign out_ch.begin_image      = out_r.begin_image;
  assign out_ch.abort_image      = out_r.abort_image;
  assign out_ch.commit_image     = out_r.commit_image;
  assign out_ch.image_size       = out_r.image_size;
  assign out_ch.image_version    = out_r.image_version;

endmodule

// ----- sv/fuhc_checker.sv -----
// -----------------------------------------------------------------------------
// fuhc_checker
// Port-level assertions for the header checker, bound to the top level.
// -----------------------------------------------------------------------------
`include "firmware_update_header_checker_top_defines.svh"

module fuhc_checker
  import fuhc_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    out_valid,
  input logic    out_ready,
  input status_t out_status,
  input logic    out_image_byte_valid,
  input logic    out_begin_image,
  input logic    out_abort_image,
  input logic    out_commit_image
);

  // A stalled result must hold its status.
  `FUHC_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_status), "result changed while stalled")

  // At most one of begin, abort and commit per result.
  `FUHC_ASSERT_NOW(a_one_pulse, out_valid, $onehot0({out_begin_image, out_abort_image, out_commit_image}), "more than one image pulse")

  // Image bytes and the begin pulse only appear while still receiving.
  `FUHC_ASSERT_NOW(a_byte_receiving, out_valid && (out_image_byte_valid || out_begin_image), out_status == ST_RECEIVING && !(out_image_byte_valid && out_begin_image), "image byte or begin outside receiving")

  // Commit means installed; abort means an error that can follow acceptance.
  `FUHC_ASSERT_NOW(a_commit_abort_status, out_valid && (out_commit_image || out_abort_image), (out_commit_image && out_status == ST_INSTALLED) || (out_abort_image && (out_status == ST_TOO_LARGE || out_status == ST_TRUNCATED || out_status == ST_BAD_SIGNATURE || out_status == ST_WRITE_ERROR)), "pulse with wrong status")

endmodule

bind firmware_update_header_checker_top fuhc_checker u_fuhc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_status           (out_ch.status),
  .out_image_byte_valid (out_ch.image_byte_valid),
  .out_begin_image      (out_ch.begin_image),
  .out_abort_image      (out_ch.abort_image),
  .out_commit_image     (out_ch.commit_image)
);

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: firmware update header checker testbench
// Runs one update stream through the checker with its own scoreboard model.
// The header is built per run, good or broken in one chosen way, and the
// image is ended one of several ways. Stream and result sides idle at random,
// and the configuration is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import fuhc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AFTER = 150;
  localparam int HOLD_CYCLES = 48;
  localparam out_item_t IDLE_RESULT =
    '{ST_RECEIVING, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0};

  typedef enum {
    PLAN_ACCEPT, PLAN_BAD_HEADER, PLAN_WRONG_ROLE, PLAN_DOWNGRADE, PLAN_TOO_LARGE,
    PLAN_HDR_WRITE_FAIL, PLAN_HDR_CANCEL, PLAN_HDR_FINISH
  } hdr_plan_t;

  typedef enum {
    END_INSTALL, END_BAD_SIG, END_FINISH_FAIL, END_EARLY, END_CANCEL, END_OVERRUN,
    END_IMG_FAIL
  } end_plan_t;

  typedef struct {
    mode_t     mode;
    byte_t     data;
    bit        wf;
    bit        sv;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  word_t    cfg_wdata;

  fuhc_in_if  in_ch ();
  fuhc_out_if out_ch ();

  firmware_update_header_checker_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Scoreboard copy of the checker state and its registers.
  status_t upd_status;
  int      hdr_seen;
  bit      hdr_bad;
  bit      role_bad;
  byte_t   sig_len;
  word_t   ver_acc;
  word_t   size_acc;
  word_t   img_count;
  byte_t   role_cfg;
  word_t   floor_version;
  word_t   size_limit;

  out_item_t forecast [$];
  int errors;
  int items_sent;
  int results_seen;
  int reg_writes;
  int burst_left;
  int cycle_count;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Moves the status to an error; the abort pulse fires only once the header
  // had been accepted.
  function automatic bit fail_with(status_t code);
    bit pulse;
    pulse = (upd_status == ST_RECEIVING) && (hdr_seen >= HEADER_BYTES);
    upd_status = code;
    return pulse;
  endfunction

  function automatic out_item_t judge_item(mode_t mode, byte_t b, bit wf, bit sv);
    out_item_t r;
    r = IDLE_RESULT;
    if (upd_status == ST_RECEIVING) begin
      case (mode)
        MODE_DATA: begin
          if (hdr_seen < HEADER_BYTES) begin
            if (hdr_seen < 4) begin
              if (b != MAGIC[hdr_seen]) hdr_bad = 1'b1;
            end else if (hdr_seen == POS_FORMAT) begin
              if (b != FORMAT_ID) hdr_bad = 1'b1;
            end else if (hdr_seen == POS_ROLE) begin
              if (b != role_cfg) role_bad = 1'b1;
            end else if (hdr_seen == POS_RESERVED || hdr_seen == POS_RESERVED + 1) begin
              if (b != 8'h00) hdr_bad = 1'b1;
            end else if (hdr_seen < POS_SIZE) begin
              ver_acc = {ver_acc[23:0], b};
            end else if (hdr_seen < POS_SIGLEN) begin
              size_acc = {size_acc[23:0], b};
            end else if (hdr_seen == POS_SIGLEN) begin
              sig_len = b;
              if (b == 8'h00 || b > SIG_CAPACITY) hdr_bad = 1'b1;
            end else if (hdr_seen - POS_SIG >= sig_len && b != 8'h00) begin
              hdr_bad = 1'b1;
            end
            hdr_seen++;
            if (hdr_seen == HEADER_BYTES) begin
              if (hdr_bad) upd_status = ST_BAD_HEADER;
              else if (role_bad) upd_status = ST_WRONG_ROLE;
              else if (floor_version != 0 && ver_acc < floor_version)
                upd_status = ST_DOWNGRADE;
              else if (size_acc == 0 || size_acc > size_limit) upd_status = ST_TOO_LARGE;
              else if (wf) upd_status = ST_WRITE_ERROR;
              else r.begin_image = 1'b1;
            end
          end else if (img_count >= size_acc) begin
            r.abort_image = fail_with(ST_TOO_LARGE);
          end else if (wf) begin
            r.abort_image = fail_with(ST_WRITE_ERROR);
          end else begin
            r.image_byte_valid = 1'b1;
            r.image_byte = b;
            img_count++;
          end
        end
        MODE_FINISH: begin
          if (hdr_seen < HEADER_BYTES || img_count != size_acc)
            r.abort_image = fail_with(ST_TRUNCATED);
          else if (wf) r.abort_image = fail_with(ST_WRITE_ERROR);
          else if (!sv) r.abort_image = fail_with(ST_BAD_SIGNATURE);
          else begin
            upd_status = ST_INSTALLED;
            r.commit_image = 1'b1;
          end
        end
        MODE_CANCEL: r.abort_image = fail_with(ST_TRUNCATED);
        default: ;
      endcase
    end
    r.status = upd_status;
    r.image_size = size_acc;
    r.image_version = ver_acc;
    return r;
  endfunction

  function automatic void check_field(string name, word_t want, word_t got);
    if (want !== got) begin
      errors++;
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (forecast.size() == 0) begin
        errors++;
        $error("result transaction arrived with nothing expected");
      end else begin
        want = forecast.pop_front();
        check_field("status", word_t'(want.status), word_t'(out_ch.status));
        check_field("image_byte_valid", word_t'(want.image_byte_valid),
                    word_t'(out_ch.image_byte_valid));
        check_field("image_byte", word_t'(want.image_byte), word_t'(out_ch.image_byte));
        check_field("begin_image", word_t'(want.begin_image), word_t'(out_ch.begin_image));
        check_field("abort_image", word_t'(want.abort_image), word_t'(out_ch.abort_image));
        check_field("commit_image", word_t'(want.commit_image),
                    word_t'(out_ch.commit_image));
        check_field("image_size", want.image_size, out_ch.image_size);
        check_field("image_version", want.image_version, out_ch.image_version);
      end
    end
  end

  // Result side: ready follows a randomly redrawn mood, plus one
  // long hold-off so the skid buffer fills and the input stalls.
  initial begin : result_drain
    int mood;
    int mood_left;
    int hold_left;
    bit held;
    bit rdy;
    mood = 0;
    mood_left = 0;
    hold_left = 0;
    held = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mood_left == 0) begin
        mood = $urandom_range(0, 3);
        mood_left = 32;
      end
      mood_left--;
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      case (mood)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        2: rdy = bit'($urandom_range(0, 1));
        default: rdy = ($urandom_range(0, 7) == 0);
      endcase
      if (hold_left > 0) begin
        rdy = 1'b0;
        hold_left--;
      end
      out_ch.ready <= rdy;
    end
  end

  // Offers one stream transaction and records its expected result once taken.
  task automatic push_item(mode_t m, byte_t d, bit wf, bit sv, bit typed,
                           out_item_t want);
    int gap;
    out_item_t calc;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = 64;
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 6);
      end
      repeat (gap) @(negedge clk) in_ch.valid <= 1'b0;
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.mode <= m;
    in_ch.data_byte <= d;
    in_ch.write_failed <= wf;
    in_ch.signature_valid <= sv;
    do @(posedge clk); while (!in_ch.ready);
    calc = judge_item(m, d, wf, sv);
    forecast.push_back(typed ? want : calc);
    items_sent++;
  endtask

  task automatic maybe_nop();
    if ($urandom_range(0, 15) == 0)
      push_item(MODE_NOP, byte_t'($urandom), bit'($urandom_range(0, 1)),
                bit'($urandom_range(0, 1)), 1'b0, IDLE_RESULT);
  endtask

  // Stops offering and waits for every outstanding result.
  task automatic settle();
    @(negedge clk) in_ch.valid <= 1'b0;
    while (forecast.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, word_t val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_EXPECTED_ROLE:   role_cfg = val[7:0];
      CFG_RUNNING_VERSION: floor_version = val;
      CFG_MAX_IMAGE_BYTES: size_limit = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic program_regs(word_t role_w, word_t rv_w, word_t mx_w);
    settle();
    write_reg(CFG_EXPECTED_ROLE, role_w);
    write_reg(CFG_UNUSED, $urandom);
    write_reg(CFG_RUNNING_VERSION, rv_w);
    write_reg(CFG_MAX_IMAGE_BYTES, mx_w);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    byte_t     hdr [HEADER_BYTES];
    stim_row_t dir_rows [$];
    stim_row_t row;
    hdr_plan_t hdr_plan;
    end_plan_t end_plan;
    word_t     role_w;
    word_t     rv_w;
    word_t     mx_w;
    word_t     size_w;
    word_t     ver_w;
    int        sig_n;
    int        cut_at;
    int        img_len;
    int        noise_n;
    bit        cut;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_EXPECTED_ROLE;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_NOP;
    in_ch.data_byte = '0;
    in_ch.write_failed = 1'b0;
    in_ch.signature_valid = 1'b0;
    upd_status = ST_RECEIVING;
    hdr_seen = 0;
    hdr_bad = 1'b0;
    role_bad = 1'b0;
    sig_len = '0;
    ver_acc = '0;
    size_acc = '0;
    img_count = '0;
    role_cfg = '0;
    floor_version = '0;
    size_limit = MAX_IMAGE_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Initial register setting; a quarter of the runs keep the reset values.
    if ($urandom_range(0, 3) != 0) begin
      role_w = $urandom;
      case ($urandom_range(0, 3))
        0: role_w[7:0] = 8'h00;
        1: role_w[7:0] = 8'hFF;
        default: ;
      endcase
      case ($urandom_range(0, 5))
        0, 1: rv_w = '0;
        2: rv_w = '1;
        default: rv_w = $urandom;
      endcase
      case ($urandom_range(0, 11))
        0: mx_w = '0;
        1, 2: mx_w = '1;
        3, 4, 5: mx_w = $urandom_range(1, 600);
        default: mx_w = MAX_IMAGE_RESET;
      endcase
      program_regs(role_w, rv_w, mx_w);
    end

    case ($urandom_range(0, 19))
      0, 1: hdr_plan = PLAN_BAD_HEADER;
      2: hdr_plan = PLAN_WRONG_ROLE;
      3: hdr_plan = PLAN_DOWNGRADE;
      4: hdr_plan = PLAN_TOO_LARGE;
      5: hdr_plan = PLAN_HDR_WRITE_FAIL;
      6: hdr_plan = PLAN_HDR_CANCEL;
      7: hdr_plan = PLAN_HDR_FINISH;
      default: hdr_plan = PLAN_ACCEPT;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: end_plan = END_INSTALL;
      4: end_plan = END_BAD_SIG;
      5: end_plan = END_FINISH_FAIL;
      6: end_plan = END_EARLY;
      7: end_plan = END_CANCEL;
      8: end_plan = END_OVERRUN;
      default: end_plan = END_IMG_FAIL;
    endcase

    // Build the header for this run.
    size_w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : $urandom_range(300, 500);
    if (size_limit != 0 && size_w > size_limit) size_w = size_limit;
    ver_w = (floor_version == 0) ? $urandom : (floor_version | $urandom);
    if ($urandom_range(0, 5) == 0) ver_w = floor_version;
    if (hdr_plan == PLAN_DOWNGRADE && floor_version != 0) ver_w = (floor_version - 1) & $urandom;
    if (hdr_plan == PLAN_TOO_LARGE)
      size_w = (size_limit == '1 || $urandom_range(0, 1) == 0) ? '0 : size_limit + 1;
    case ($urandom_range(0, 3))
      0: sig_n = 1;
      1: sig_n = SIG_CAPACITY;
      default: sig_n = $urandom_range(2, SIG_CAPACITY - 1);
    endcase
    for (int i = 0; i < 4; i++) begin
      hdr[i] = MAGIC[i];
      hdr[POS_VERSION + i] = ver_w[31 - 8 * i -: 8];
      hdr[POS_SIZE + i] = size_w[31 - 8 * i -: 8];
    end
    hdr[POS_FORMAT] = FORMAT_ID;
    hdr[POS_ROLE] = role_cfg;
    hdr[POS_RESERVED] = 8'h00;
    hdr[POS_RESERVED + 1] = 8'h00;
    hdr[POS_SIGLEN] = byte_t'(sig_n);
    for (int pos = POS_SIG; pos < HEADER_BYTES; pos++)
      hdr[pos] = (pos - POS_SIG < sig_n) ? byte_t'($urandom) : 8'h00;
    if (hdr_plan == PLAN_BAD_HEADER) begin
      case ($urandom_range(0, 4))
        0: hdr[$urandom_range(0, 4)] ^= byte_t'($urandom_range(1, 255));
        1: hdr[POS_RESERVED + $urandom_range(0, 1)] = byte_t'($urandom_range(1, 255));
        2: hdr[POS_SIGLEN] = 8'h00;
        3: hdr[POS_SIGLEN] = byte_t'($urandom_range(SIG_CAPACITY + 1, 255));
        default: hdr[$urandom_range(POS_SIG + sig_n, HEADER_BYTES - 1)] =
                   byte_t'($urandom_range(1, 255));
      endcase
      // Sometimes the role is wrong as well; the malformed verdict must win.
      if ($urandom_range(0, 1) == 0) hdr[POS_ROLE] ^= 8'h01;
    end
    if (hdr_plan == PLAN_WRONG_ROLE) hdr[POS_ROLE] ^= byte_t'($urandom_range(1, 255));

    // Directed opening: ignored no-ops at the field extremes, then the magic
    // bytes with write failures that the header must ignore, then the fixed
    // fields up to the signature length.
    for (int i = 0; i < 4; i++) begin
      row.mode = MODE_NOP;
      row.data = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : (i == 2) ? 8'h55 : 8'hAA;
      row.wf = i[0];
      row.sv = i[1] ^ i[0];
      row.typed = 1'b1;
      row.want = IDLE_RESULT;
      dir_rows.push_back(row);
    end
    for (int pos = 0; pos <= POS_SIGLEN; pos++) begin
      row.mode = MODE_DATA;
      row.data = hdr[pos];
      row.wf = (pos < 4) ? pos[0] : bit'($urandom_range(0, 1));
      row.sv = bit'($urandom_range(0, 1));
      row.typed = (pos < 4);
      row.want = IDLE_RESULT;
      dir_rows.push_back(row);
    end
    foreach (dir_rows[i])
      push_item(dir_rows[i].mode, dir_rows[i].data, dir_rows[i].wf, dir_rows[i].sv,
                dir_rows[i].typed, dir_rows[i].want);

    // Remainder of the header, possibly cut short by a cancel or finish.
    cut = (hdr_plan == PLAN_HDR_CANCEL || hdr_plan == PLAN_HDR_FINISH);
    cut_at = $urandom_range(POS_SIG, HEADER_BYTES - 1);
    for (int pos = POS_SIG; pos < HEADER_BYTES; pos++) begin
      if (cut && pos == cut_at) break;
      maybe_nop();
      push_item(MODE_DATA, hdr[pos],
                (pos == HEADER_BYTES - 1) ? (hdr_plan == PLAN_HDR_WRITE_FAIL)
                                          : bit'($urandom_range(0, 1)),
                bit'($urandom_range(0, 1)), 1'b0, IDLE_RESULT);
    end
    if (cut)
      push_item((hdr_plan == PLAN_HDR_CANCEL) ? MODE_CANCEL : MODE_FINISH,
                byte_t'($urandom), bit'($urandom_range(0, 1)),
                bit'($urandom_range(0, 1)), 1'b0, IDLE_RESULT);

    // Extreme settings once the header is judged; they must change nothing.
    role_w = $urandom;
    role_w[7:0] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
    program_regs(role_w, ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF,
                 ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF);

    if (hdr_plan == PLAN_ACCEPT || hdr_plan == PLAN_DOWNGRADE) begin
      case (end_plan)
        END_EARLY, END_IMG_FAIL: img_len = $urandom_range(0, size_w - 1);
        END_CANCEL: img_len = $urandom_range(0, size_w);
        default: img_len = size_w;
      endcase
      repeat (img_len) begin
        maybe_nop();
        push_item(MODE_DATA, byte_t'($urandom), 1'b0, bit'($urandom_range(0, 1)), 1'b0,
                  IDLE_RESULT);
      end
      case (end_plan)
        END_BAD_SIG:
          push_item(MODE_FINISH, byte_t'($urandom), 1'b0, 1'b0, 1'b0, IDLE_RESULT);
        END_FINISH_FAIL:
          push_item(MODE_FINISH, byte_t'($urandom), 1'b1, bit'($urandom_range(0, 1)),
                    1'b0, IDLE_RESULT);
        END_EARLY:
          push_item(MODE_FINISH, byte_t'($urandom), bit'($urandom_range(0, 1)),
                    bit'($urandom_range(0, 1)), 1'b0, IDLE_RESULT);
        END_CANCEL:
          push_item(MODE_CANCEL, byte_t'($urandom), bit'($urandom_range(0, 1)),
                    bit'($urandom_range(0, 1)), 1'b0, IDLE_RESULT);
        END_OVERRUN:
          push_item(MODE_DATA, byte_t'($urandom), bit'($urandom_range(0, 1)),
                    bit'($urandom_range(0, 1)), 1'b0, IDLE_RESULT);
        END_IMG_FAIL:
          push_item(MODE_DATA, byte_t'($urandom), 1'b1, bit'($urandom_range(0, 1)),
                    1'b0, IDLE_RESULT);
        default:
          push_item(MODE_FINISH, byte_t'($urandom), 1'b0, 1'b1, 1'b0, IDLE_RESULT);
      endcase
    end

    program_regs($urandom, $urandom, $urandom);

    // Any mix of transactions after the verdict; the status must hold.
    noise_n = (items_sent < 620) ? 650 - items_sent : 30;
    repeat (noise_n)
      push_item(mode_t'($urandom_range(0, 3)), byte_t'($urandom),
                bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)), 1'b0,
                IDLE_RESULT);

    settle();
    repeat (5) @(posedge clk);
    $display("Covered %0d stream transactions, %0d checked results, %0d register writes.",
             items_sent, results_seen, reg_writes);
    $display("The update ended as %s after %0d of %0d declared image bytes.",
             upd_status.name(), img_count, size_acc);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
